@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl files that carry checks
// uses the clk and rst_n names of the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define GSE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define GSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/gse_pkg.sv @@
// shared types, constants and field map of the gga field extractor
// no dependencies
package gse_pkg;

  localparam int unsigned TIME_CHARS = 10;
  localparam int unsigned LAT_CHARS  = 10;
  localparam int unsigned LON_CHARS  = 11;
  localparam int unsigned SAT_CHARS  = 2;
  localparam int unsigned ALT_CHARS  = 8;

  localparam logic [7:0] START_CHAR  = 8'h24;
  localparam logic [7:0] SEP_CHAR    = 8'h2C;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  localparam logic [2:0] HDR_LEN   = 3'd6;
  localparam logic [3:0] ALT_FIELD = 4'd9;
  localparam logic [3:0] FC_MAX    = 4'd15;
  localparam logic [4:0] CI_MAX    = 5'd31;

  localparam logic [2:0] FID_TIME    = 3'd0;
  localparam logic [2:0] FID_LAT     = 3'd1;
  localparam logic [2:0] FID_LAT_DIR = 3'd2;
  localparam logic [2:0] FID_LON     = 3'd3;
  localparam logic [2:0] FID_LON_DIR = 3'd4;
  localparam logic [2:0] FID_QUALITY = 3'd5;
  localparam logic [2:0] FID_SATS    = 3'd6;
  localparam logic [2:0] FID_ALT     = 3'd7;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_START = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [2:0] field_id;
    logic [3:0] position;
    logic [7:0] char_value;
  } res_t;

  typedef struct packed {
    logic       en;
    logic [2:0] id;
    logic [4:0] limit;
  } fmap_t;

  // expected header letter at each match index
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h47;
      3'd5:    c = 8'h41;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // field number to output id and kept length
  function automatic fmap_t field_map(input logic [3:0] fc);
    fmap_t m;
    m = '{en: 1'b0, id: FID_TIME, limit: 5'd0};
    case (fc)
      4'd1:    m = '{en: 1'b1, id: FID_TIME,    limit: 5'(TIME_CHARS)};
      4'd2:    m = '{en: 1'b1, id: FID_LAT,     limit: 5'(LAT_CHARS)};
      4'd3:    m = '{en: 1'b1, id: FID_LAT_DIR, limit: 5'd1};
      4'd4:    m = '{en: 1'b1, id: FID_LON,     limit: 5'(LON_CHARS)};
      4'd5:    m = '{en: 1'b1, id: FID_LON_DIR, limit: 5'd1};
      4'd6:    m = '{en: 1'b1, id: FID_QUALITY, limit: 5'd1};
      4'd7:    m = '{en: 1'b1, id: FID_SATS,    limit: 5'(SAT_CHARS)};
      4'd9:    m = '{en: 1'b1, id: FID_ALT,     limit: 5'(ALT_CHARS)};
      default: m = '{en: 1'b0, id: FID_TIME,    limit: 5'd0};
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/gse_parse.sv @@
// header match and field counter of the gga extractor, one byte per cycle while byte_en is high
// depends on gse_pkg
module gse_parse (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_en,
  input  logic [7:0]      rx_byte,
  output gse_pkg::res_t   res
);

  logic [2:0] hdr_idx_r, hdr_idx_nxt;
  logic [3:0] fcount_r,  fcount_nxt;
  logic [4:0] cidx_r,    cidx_nxt;
  logic       in_sent_r, in_sent_nxt;
  gse_pkg::fmap_t fm;

  assign fm = gse_pkg::field_map(fcount_r);

  always_comb begin
    hdr_idx_nxt = hdr_idx_r;
    fcount_nxt  = fcount_r;
    cidx_nxt    = cidx_r;
    in_sent_nxt = in_sent_r;
    res         = '{valid: 1'b0, kind: gse_pkg::KIND_CHAR, field_id: 3'd0,
                    position: 4'd0, char_value: 8'd0};
    if (rx_byte == gse_pkg::START_CHAR) begin
      hdr_idx_nxt = 3'd1;
      in_sent_nxt = 1'b0;
    end else if (!in_sent_r) begin
      if (hdr_idx_r == 3'd0 || hdr_idx_r >= gse_pkg::HDR_LEN) begin
        hdr_idx_nxt = 3'd0;
      end else if (rx_byte != gse_pkg::hdr_char(hdr_idx_r)) begin
        hdr_idx_nxt = 3'd0;
      end else if (hdr_idx_r + 3'd1 < gse_pkg::HDR_LEN) begin
        hdr_idx_nxt = hdr_idx_r + 3'd1;
      end else begin
        hdr_idx_nxt = 3'd0;
        in_sent_nxt = 1'b1;
        fcount_nxt  = 4'd0;
        cidx_nxt    = 5'd0;
        res.valid   = 1'b1;
        res.kind    = gse_pkg::KIND_START;
      end
    end else if (rx_byte == gse_pkg::SEP_CHAR) begin
      cidx_nxt = 5'd0;
      if (fcount_r == gse_pkg::ALT_FIELD) begin
        in_sent_nxt = 1'b0;
        fcount_nxt  = 4'd0;
        res.valid   = 1'b1;
        res.kind    = gse_pkg::KIND_DONE;
      end else if (fcount_r < gse_pkg::FC_MAX) begin
        fcount_nxt = fcount_r + 4'd1;
      end
    end else begin
      if (cidx_r < gse_pkg::CI_MAX) begin
        cidx_nxt = cidx_r + 5'd1;
      end
      if (fm.en && cidx_r < fm.limit) begin
        res.valid      = 1'b1;
        res.kind       = gse_pkg::KIND_CHAR;
        res.field_id   = fm.id;
        res.position   = cidx_r[3:0];
        res.char_value = (fm.id == gse_pkg::FID_QUALITY) ?
                         (rx_byte & gse_pkg::NIBBLE_MASK) : rx_byte;
      end
    end
    if (!byte_en) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_idx_r <= 3'd0;
      fcount_r  <= 4'd0;
      cidx_r    <= 5'd0;
      in_sent_r <= 1'b0;
    end else if (byte_en) begin
      hdr_idx_r <= hdr_idx_nxt;
      fcount_r  <= fcount_nxt;
      cidx_r    <= cidx_nxt;
      in_sent_r <= in_sent_nxt;
    end
  end

endmodule

@@ rtl/core/gse_out_buf.sv @@
// result register with skid stage for the gga extractor output
// depends on gse_pkg
module gse_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  gse_pkg::res_t push,
  output logic          push_ready,
  output gse_pkg::res_t head,
  input  logic          pop
);

  gse_pkg::res_t out_r, out_nxt;
  gse_pkg::res_t skid_r, skid_nxt;

  assign push_ready = !skid_r.valid;
  assign head       = out_r;

  always_comb begin
    out_nxt  = out_r;
    skid_nxt = skid_r;
    if (!out_r.valid || pop) begin
      if (skid_r.valid) begin
        out_nxt        = skid_r;
        skid_nxt.valid = 1'b0;
      end else begin
        out_nxt = push;
      end
    end else if (push.valid) begin
      skid_nxt = push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid  <= 1'b0;
      skid_r.valid <= 1'b0;
    end else begin
      out_r.valid  <= out_nxt.valid;
      skid_r.valid <= skid_nxt.valid;
    end
    out_r.kind        <= out_nxt.kind;
    out_r.field_id    <= out_nxt.field_id;
    out_r.position    <= out_nxt.position;
    out_r.char_value  <= out_nxt.char_value;
    skid_r.kind       <= skid_nxt.kind;
    skid_r.field_id   <= skid_nxt.field_id;
    skid_r.position   <= skid_nxt.position;
    skid_r.char_value <= skid_nxt.char_value;
  end

endmodule

@@ rtl/core/gga_sentence_field_extractor.sv @@
// top level of the gga sentence field extractor
// depends on gse_pkg, gse_parse, gse_out_buf and assert_macros.svh
//
//   channel | direction | request contents
//   in_     | slave     | one received sentence byte
//   out_    | master    | tagged field character, start or completion marker
//
// one byte is taken per cycle while in_tready is high; a result is registered before out_tvalid
// the parser state, the result register and the skid stage are the only logic between bytes
// in_tready drops only while both the result register and the skid stage are full
// rst_n is synchronous and returns the parser to idle with no results pending
`include "assert_macros.svh"

module gga_sentence_field_extractor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gse_pkg::IN_DATA_W-1:0]    in_tdata,   // [7:0] rx_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gse_pkg::OUT_DATA_W-1:0]   out_tdata,  // [2:0] field_id, [6:3] position,
                                                       // [14:7] char_value, [15] zero
  output logic [gse_pkg::OUT_USER_W-1:0]   out_tuser   // [1:0] kind
);

  gse_pkg::res_t res;
  gse_pkg::res_t head;
  logic          byte_en;

  assign byte_en = in_tvalid && in_tready;

  gse_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (byte_en),
    .rx_byte (in_tdata),
    .res     (res)
  );

  gse_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res),
    .push_ready (in_tready),
    .head       (head),
    .pop        (out_tvalid && out_tready)
  );

  assign out_tvalid = head.valid;
  assign out_tuser  = head.kind;
  assign out_tdata  = {1'b0, head.char_value, head.position, head.field_id};

  `GSE_ASSERT_SAME(a_stall_only_when_full, !in_tready, out_tvalid,
                   "input stalled while output register empty")
  `GSE_ASSERT_SAME(a_marker_payload_zero,
                   out_tvalid && out_tuser != gse_pkg::KIND_CHAR, out_tdata == '0,
                   "start or completion marker carries payload")
  `GSE_ASSERT_SAME(a_quality_nibble,
                   out_tvalid && out_tuser == gse_pkg::KIND_CHAR &&
                   out_tdata[2:0] == gse_pkg::FID_QUALITY,
                   out_tdata[14:11] == 4'd0,
                   "quality character wider than a nibble")
  `GSE_ASSERT_NEXT(a_stall_releases, !in_tready && out_tready, in_tready,
                   "input ready not restored after output drained")

endmodule

@@ tb/gse_tb_pkg.sv @@
`timescale 1ns / 100ps
// expected-result tracker for the gga sentence field extractor testbench
// depends on gse_pkg for the result kinds, field ids and field lengths
package gse_tb_pkg;
  import gse_pkg::*;

  localparam string GGA_HEADER = "$GPGGA";

  typedef struct packed {
    kind_t      kind;
    logic [2:0] fid;
    logic [3:0] pos;
    logic [7:0] ch;
  } field_result_t;

  class gga_field_tracker;
    logic [2:0]    hdr_pos;
    logic [3:0]    commas;
    logic [4:0]    col;
    bit            in_sentence;
    field_result_t awaited[$];
    int unsigned   errors;

    function new();
      hdr_pos     = '0;
      commas      = '0;
      col         = '0;
      in_sentence = 1'b0;
      errors      = 0;
    endfunction

    task report(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function int unsigned waiting();
      return awaited.size();
    endfunction

    // advance the parser by one accepted byte and queue what it should emit
    function void take_byte(input logic [7:0] b);
      logic [4:0]  pos;
      logic [2:0]  fid;
      int unsigned keep;
      bit          hit;
      hit  = 1'b1;
      fid  = FID_TIME;
      keep = 0;
      if (b == START_CHAR) begin
        hdr_pos     = 3'd1;
        in_sentence = 1'b0;
        return;
      end
      if (!in_sentence) begin
        if (hdr_pos == 3'd0 || hdr_pos >= HDR_LEN || b != GGA_HEADER[hdr_pos]) begin
          hdr_pos = 3'd0;
          return;
        end
        hdr_pos = hdr_pos + 3'd1;
        if (hdr_pos < HDR_LEN) return;
        hdr_pos     = 3'd0;
        in_sentence = 1'b1;
        commas      = '0;
        col         = '0;
        awaited.push_back('{kind: KIND_START, fid: 3'd0, pos: 4'd0, ch: 8'd0});
        return;
      end
      if (b == SEP_CHAR) begin
        if (commas == ALT_FIELD) begin
          in_sentence = 1'b0;
          commas      = '0;
          col         = '0;
          awaited.push_back('{kind: KIND_DONE, fid: 3'd0, pos: 4'd0, ch: 8'd0});
          return;
        end
        if (commas < FC_MAX) commas = commas + 4'd1;
        col = '0;
        return;
      end
      pos = col;
      if (col < CI_MAX) col = col + 5'd1;
      case (commas)
        4'd1:    begin fid = FID_TIME;    keep = TIME_CHARS; end
        4'd2:    begin fid = FID_LAT;     keep = LAT_CHARS;  end
        4'd3:    begin fid = FID_LAT_DIR; keep = 1;          end
        4'd4:    begin fid = FID_LON;     keep = LON_CHARS;  end
        4'd5:    begin fid = FID_LON_DIR; keep = 1;          end
        4'd6:    begin fid = FID_QUALITY; keep = 1;          end
        4'd7:    begin fid = FID_SATS;    keep = SAT_CHARS;  end
        4'd9:    begin fid = FID_ALT;     keep = ALT_CHARS;  end
        default: hit = 1'b0;
      endcase
      if (hit && pos < keep)
        awaited.push_back('{kind: KIND_CHAR, fid: fid, pos: pos[3:0],
                            ch: (fid == FID_QUALITY) ? (b & NIBBLE_MASK) : b});
    endfunction

    task match_result(input logic [1:0] user, input logic [15:0] data);
      field_result_t e;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing expected, tuser %0d tdata %h", user, data));
        return;
      end
      e = awaited.pop_front();
      if (user != e.kind)
        report($sformatf("kind %0d, expected %0d", user, e.kind));
      if (data[2:0] != e.fid)
        report($sformatf("field id %0d, expected %0d", data[2:0], e.fid));
      if (data[6:3] != e.pos)
        report($sformatf("position %0d, expected %0d", data[6:3], e.pos));
      if (data[14:7] != e.ch)
        report($sformatf("char %h, expected %h", data[14:7], e.ch));
      if (data[15] !== 1'b0)
        report("pad bit of tdata not zero");
    endtask

    task final_check();
      if (awaited.size() != 0)
        report($sformatf("%0d expected results never arrived", awaited.size()));
    endtask
  endclass

endpackage

@@ tb/tb_gga_sentence_field_extractor.sv @@
`timescale 1ns / 100ps
// top-level testbench of the gga sentence field extractor: directed and random byte
// streams with bursty input and stalling output; depends on gse_pkg and gse_tb_pkg
module tb_gga_sentence_field_extractor;
  import gse_pkg::*;
  import gse_tb_pkg::*;

  localparam int unsigned FIELD_KEEP[9] = '{TIME_CHARS, LAT_CHARS, 1, LON_CHARS, 1, 1,
                                            SAT_CHARS, 4, ALT_CHARS};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  gga_field_tracker board;
  int unsigned      taken_bytes;
  int unsigned      sent_bytes;
  int unsigned      burst_left;
  bit               draining;

  gga_sentence_field_extractor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        board.take_byte(in_tdata);
        taken_bytes++;
      end
      if (out_tvalid && out_tready) board.match_result(out_tuser, out_tdata);
    end
  end

  // receiver: changing stall patterns plus two long hold-offs
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned cyc;
    int unsigned holds_done;
    bit          r;
    mode       = 0;
    mode_left  = 0;
    hold_left  = 0;
    cyc        = 0;
    holds_done = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      if (hold_left == 0 && holds_done < 2 && taken_bytes > 500 + 800 * holds_done) begin
        hold_left = 300;
        holds_done++;
      end
      case (mode)
        0:       r = 1'b1;
        1:       r = 1'($urandom_range(0, 1));
        2:       r = (cyc % 4) != 0;
        default: r = $urandom_range(0, 3) == 0;
      endcase
      if (hold_left != 0) begin
        hold_left--;
        r = 1'b0;
      end
      out_tready <= r | draining;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    sent_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] field_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == SEP_CHAR || c == START_CHAR);
    return c;
  endfunction

  // well-formed sentence with random field lengths, sometimes cut short by a dollar
  task automatic send_sentence();
    int unsigned n;
    int unsigned cut;
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 0;
    send_text(GGA_HEADER);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_byte(field_char());
    for (int f = 1; f <= 9; f++) begin
      send_byte(SEP_CHAR);
      if (f == cut) begin
        send_byte(START_CHAR);
        return;
      end
      n = $urandom_range(0, FIELD_KEEP[f - 1] + 2);
      if ($urandom_range(0, 15) == 0) n = $urandom_range(20, 40);
      repeat (n) send_byte(field_char());
    end
    send_byte(SEP_CHAR);
  endtask

  task automatic send_broken_header();
    int unsigned k;
    logic [7:0]  c;
    k = $urandom_range(1, 5);
    do c = 8'($urandom_range(0, 255)); while (c == GGA_HEADER[k] || c == START_CHAR);
    for (int i = 0; i < 6; i++) send_byte((i == k) ? c : GGA_HEADER[i]);
    repeat ($urandom_range(1, 6)) send_byte(field_char());
    send_byte(SEP_CHAR);
  endtask

  initial begin
    int unsigned pick;
    board       = new();
    taken_bytes = 0;
    sent_bytes  = 0;
    burst_left  = 0;
    draining    = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // idle bytes, junk before the first comma, extreme chars, empty fields,
    // quality nibble, sats truncation, skipped dilution and completion
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("$GPGGAz,");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text(",,N,,E,");
    send_byte(8'hFF);
    send_text(",12345,9,A,");

    while (sent_bytes < 1760) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      else if (pick == 1) send_broken_header();
      else send_sentence();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    draining = 1'b1;
    while (board.waiting() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    board.final_check();
    if (board.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
